### rtl/assert_macros.svh
// Assertion macros used by the RTL of the lock engage sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define LES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/les_pkg.sv
// Types and constants for the lock engage sequencer.
package les_pkg;

  // Position width of the signed Q8.16 turns format.
  localparam int unsigned PosW = 24;

  // Lock phases.
  typedef enum logic [3:0] {
    PH_UNHOMED   = 4'd0,
    PH_RELEASED  = 4'd1,
    PH_ENGAGED   = 4'd2,
    PH_WANT_ENG  = 4'd3,
    PH_WANT_REL  = 4'd4,
    PH_PRE_ENG   = 4'd5,
    PH_PRE_REL   = 4'd6,
    PH_ENGAGING  = 4'd7,
    PH_STEPBACK  = 4'd8,
    PH_RELEASING = 4'd9
  } phase_e;

  // Motor speed direction.
  typedef enum logic [1:0] {
    SPD_STOP = 2'd0,
    SPD_ENG  = 2'd1,
    SPD_REL  = 2'd2
  } speed_e;

  // Request action codes.
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_HOMED   = 2'd1,
    ACT_ENGAGE  = 2'd2,
    ACT_RELEASE = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_WAIT_CYCLES   = 3'd0,
    CFG_STOPPED_SPEED = 3'd1,
    CFG_TRIES_STOPPED = 3'd2,
    CFG_TRIES_MOVING  = 3'd3,
    CFG_STALL_LIMIT   = 3'd4,
    CFG_ENGAGED_LIMIT = 3'd5,
    CFG_RELEASE_LIMIT = 3'd6
  } cfg_idx_e;

  // Reset values.
  localparam logic [7:0]  WaitCyclesRst    = 8'd20;
  localparam logic [13:0] StoppedSpeedRst  = 14'd50;
  localparam logic [2:0]  TriesStoppedRst  = 3'd3;
  localparam logic [2:0]  TriesMovingRst   = 3'd5;
  localparam logic [7:0]  StallLimitRst    = 8'd10;
  localparam logic signed [PosW-1:0] EngagedLimitRst  = 24'sd0;
  localparam logic signed [PosW-1:0] ReleaseLimitRst  = -24'sd32768;
  localparam logic [7:0]  WaitCountRst     = 8'd20;
  localparam logic [7:0]  StallCountMax    = 8'hFF;

  // One control tick request.
  typedef struct packed {
    logic [1:0]             action;
    logic [13:0]            gear_speed;
    logic signed [PosW-1:0] measured_position;
  } les_req_t;

  // One result per tick.
  typedef struct packed {
    logic [3:0] phase;
    logic [1:0] speed_command;
    logic       motor_active;
    logic       lamp_on;
    logic [2:0] tries_rem;
  } les_res_t;

endpackage

### rtl/lock_engage_sequencer_core.sv
// Lock engage sequencer: tick input register, phase machine, result register.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_req_i): one request per control
//   tick, carrying the action, the gear speed and the measured actuator position.
// - Output channel (out_valid_o / out_stall_i / out_res_o): exactly one result
//   per request, in order: phase, speed command, motor enable, lamp, tries left.
// - Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i;
//   indexes past the last register are ignored. Write only while idle.
// Timing:
// - A request accepted into the input register is evaluated against the lock
//   state as it moves into the result register, and its result is on the
//   output from then on until the receiver takes it.
// - One request per cycle is sustained while the receiver does not stall; the
//   phase machine and the stall and wait counters follow the input register.
// - When the receiver stalls, the result register holds; the input register
//   holds too and the input stalls only once both registers are occupied.
// Reset: state goes to unhomed with the motor idle, lamp off, counters cleared,
// wait count twenty and all configuration registers at their defaults.
`include "assert_macros.svh"

module lock_engage_sequencer_core
  import les_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  les_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output les_res_t out_res_o,
  input  logic     cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [PosW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [7:0]             cfg_wait_q;
  logic [13:0]            cfg_stop_spd_q;
  logic [2:0]             cfg_tries_stop_q;
  logic [2:0]             cfg_tries_move_q;
  logic [7:0]             cfg_stall_lim_q;
  logic signed [PosW-1:0] cfg_eng_lim_q;
  logic signed [PosW-1:0] cfg_rel_lim_q;

  // Pipeline registers.
  logic     s1_valid_q;
  les_req_t s1_req_q;
  logic     out_valid_q;
  les_res_t out_res_q;
  les_res_t out_res_d;
  logic     fire;

  // Lock state.
  phase_e                 phase_q, phase_d, phase_act;
  logic signed [PosW-1:0] last_pos_q;
  logic [7:0]             wait_q, wait_d;
  logic [7:0]             stall_q, stall_d, stall_trk;
  logic [2:0]             tries_q, tries_d;
  speed_e                 speed_q, speed_d;
  logic                   motor_q, motor_d;
  logic                   lamp_q, lamp_d;
  logic                   stall_hit;
  logic signed [PosW-1:0] pos;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_wait_q       <= WaitCyclesRst;
      cfg_stop_spd_q   <= StoppedSpeedRst;
      cfg_tries_stop_q <= TriesStoppedRst;
      cfg_tries_move_q <= TriesMovingRst;
      cfg_stall_lim_q  <= StallLimitRst;
      cfg_eng_lim_q    <= EngagedLimitRst;
      cfg_rel_lim_q    <= ReleaseLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WAIT_CYCLES:   cfg_wait_q       <= cfg_data_i[7:0];
        CFG_STOPPED_SPEED: cfg_stop_spd_q   <= cfg_data_i[13:0];
        CFG_TRIES_STOPPED: cfg_tries_stop_q <= cfg_data_i[2:0];
        CFG_TRIES_MOVING:  cfg_tries_move_q <= cfg_data_i[2:0];
        CFG_STALL_LIMIT:   cfg_stall_lim_q  <= cfg_data_i[7:0];
        CFG_ENGAGED_LIMIT: cfg_eng_lim_q    <= cfg_data_i;
        CFG_RELEASE_LIMIT: cfg_rel_lim_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input register advances whenever the result register is free.
  assign fire        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !fire;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_req_q <= in_req_i;
    end
  end

  assign pos = s1_req_q.measured_position;

  // Phase after the request's action is applied.
  always_comb begin
    phase_act = phase_q;
    unique case (action_e'(s1_req_q.action))
      ACT_HOMED: begin
        if (phase_q == PH_UNHOMED) phase_act = PH_RELEASED;
      end
      ACT_ENGAGE: begin
        if (phase_q == PH_RELEASED) phase_act = PH_WANT_ENG;
      end
      ACT_RELEASE: begin
        if (phase_q == PH_ENGAGED || phase_q == PH_WANT_ENG || phase_q == PH_PRE_ENG ||
            phase_q == PH_ENGAGING || phase_q == PH_STEPBACK) begin
          phase_act = PH_WANT_REL;
        end
      end
      default: ;
    endcase
  end

  // Stall tracking: saturating count of ticks with an unchanged position.
  always_comb begin
    if (pos == last_pos_q) begin
      stall_trk = (stall_q == StallCountMax) ? stall_q : stall_q + 8'd1;
    end else begin
      stall_trk = '0;
    end
    stall_hit = stall_trk > cfg_stall_lim_q;
  end

  // Next state of the phase machine.
  always_comb begin
    phase_d = phase_act;
    wait_d  = wait_q;
    stall_d = stall_q;
    tries_d = tries_q;
    speed_d = speed_q;
    motor_d = motor_q;
    lamp_d  = lamp_q;
    // Homing completion leaves the motor idle.
    if (phase_q == PH_UNHOMED && phase_act == PH_RELEASED) begin
      speed_d = SPD_STOP;
      motor_d = 1'b0;
    end
    unique case (phase_act) inside
      PH_WANT_ENG: begin
        tries_d = (s1_req_q.gear_speed < cfg_stop_spd_q) ? cfg_tries_stop_q
                                                          : cfg_tries_move_q;
        if (tries_d != 3'd0) begin
          wait_d  = cfg_wait_q;
          phase_d = PH_PRE_ENG;
        end else begin
          phase_d = PH_WANT_REL;
        end
      end
      PH_WANT_REL: begin
        wait_d  = cfg_wait_q;
        speed_d = SPD_REL;
        motor_d = 1'b1;
        phase_d = PH_PRE_REL;
      end
      PH_PRE_ENG, PH_PRE_REL: begin
        speed_d = (phase_act == PH_PRE_ENG) ? SPD_ENG : SPD_REL;
        motor_d = 1'b1;
        if (wait_q == 8'd0) begin
          phase_d = (phase_act == PH_PRE_ENG) ? PH_ENGAGING : PH_RELEASING;
        end else begin
          wait_d = wait_q - 8'd1;
        end
      end
      PH_ENGAGING: begin
        stall_d = stall_trk;
        if (stall_hit) begin
          stall_d = '0;
          if (pos <= cfg_eng_lim_q) begin
            speed_d = SPD_STOP;
            motor_d = 1'b0;
            lamp_d  = 1'b1;
            phase_d = PH_ENGAGED;
          end else begin
            speed_d = SPD_REL;
            motor_d = 1'b1;
            wait_d  = cfg_wait_q;
            if (tries_q > 3'd1) begin
              tries_d = tries_q - 3'd1;
              phase_d = PH_STEPBACK;
            end else begin
              phase_d = PH_PRE_REL;
            end
          end
        end
      end
      PH_STEPBACK: begin
        if (wait_q == 8'd0) begin
          wait_d  = cfg_wait_q;
          speed_d = SPD_ENG;
          motor_d = 1'b1;
          phase_d = PH_PRE_ENG;
        end else begin
          wait_d = wait_q - 8'd1;
        end
      end
      PH_RELEASING: begin
        stall_d = stall_trk;
        if (stall_hit && pos > cfg_rel_lim_q) begin
          stall_d = '0;
          speed_d = SPD_STOP;
          motor_d = 1'b0;
          lamp_d  = 1'b0;
          phase_d = PH_RELEASED;
        end
      end
      default: ;
    endcase
  end

  // Result fields for this tick.
  always_comb begin
    out_res_d.phase         = phase_d;
    out_res_d.speed_command = speed_d;
    out_res_d.motor_active  = motor_d;
    out_res_d.lamp_on       = lamp_d;
    out_res_d.tries_rem     = tries_d;
  end

  // Lock state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_UNHOMED;
      last_pos_q <= '0;
      wait_q     <= WaitCountRst;
      stall_q    <= '0;
      tries_q    <= '0;
      speed_q    <= SPD_STOP;
      motor_q    <= 1'b0;
      lamp_q     <= 1'b0;
    end else if (fire) begin
      phase_q    <= phase_d;
      last_pos_q <= pos;
      wait_q     <= wait_d;
      stall_q    <= stall_d;
      tries_q    <= tries_d;
      speed_q    <= speed_d;
      motor_q    <= motor_d;
      lamp_q     <= lamp_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= out_res_d;
    end
  end

  // The motor is enabled exactly when a drive direction is commanded.
  `LES_ASSERT(a_motor_speed, motor_q == (speed_q != SPD_STOP), "motor and speed disagree")
  // The lamp is never lit in the unhomed or released phases.
  `LES_ASSERT(a_lamp_phase, !lamp_q || phase_q > PH_RELEASED, "lamp lit while released")
  // A request held in the input register is not lost while the output stalls.
  `LES_ASSERT_NEXT(a_s1_hold, in_stall_o, s1_valid_q && $stable(s1_req_q), "request dropped")

endmodule

### dv/lock_engage_sequencer_core_tb.sv
// Self-checking testbench for the lock engage sequencer core.
`timescale 1ns / 1ps

module lock_engage_sequencer_core_tb;
  import les_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  // Shadow copy of the configuration registers.
  typedef struct {
    logic [7:0]             wait_cycles;
    logic [13:0]            stopped_speed;
    logic [2:0]             tries_stopped;
    logic [2:0]             tries_moving;
    logic [7:0]             stall_limit;
    logic signed [PosW-1:0] engaged_limit;
    logic signed [PosW-1:0] release_limit;
  } lock_cfg_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  les_req_t        in_req_i;
  logic            out_valid_o;
  logic            out_stall_i;
  les_res_t        out_res_o;
  logic            cfg_we_i;
  logic [2:0]      cfg_index_i;
  logic [PosW-1:0] cfg_data_i;

  lock_engage_sequencer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predicted lock state, kept in step with every accepted request.
  lock_cfg_t lock_cfg = '{
    wait_cycles:   WaitCyclesRst,
    stopped_speed: StoppedSpeedRst,
    tries_stopped: TriesStoppedRst,
    tries_moving:  TriesMovingRst,
    stall_limit:   StallLimitRst,
    engaged_limit: EngagedLimitRst,
    release_limit: ReleaseLimitRst
  };
  phase_e                 lock_phase    = PH_UNHOMED;
  speed_e                 lock_speed    = SPD_STOP;
  logic                   lock_motor    = 1'b0;
  logic                   lock_lamp     = 1'b0;
  logic [2:0]             lock_tries    = 3'd0;
  logic [7:0]             lock_wait     = WaitCountRst;
  logic [7:0]             lock_stall    = 8'd0;
  logic signed [PosW-1:0] lock_last_pos = '0;

  les_res_t pending_results[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       hold_left = 0;
  bit       steady_mode = 1'b0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit; a run that gets here has hung.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Counts unchanged positions and tells whether a stall is declared.
  function automatic bit stall_seen(logic signed [PosW-1:0] pos);
    if (pos == lock_last_pos) begin
      if (lock_stall != StallCountMax) lock_stall++;
    end else begin
      lock_stall = 8'd0;
    end
    return lock_stall > lock_cfg.stall_limit;
  endfunction

  // Applies one tick to the predicted state and returns the expected result.
  function automatic les_res_t advance_lock(les_req_t req);
    logic signed [PosW-1:0] pos;
    les_res_t res;
    pos = req.measured_position;

    // The request's action takes effect before the phase machine runs.
    case (req.action)
      ACT_HOMED: begin
        if (lock_phase == PH_UNHOMED) begin
          lock_phase = PH_RELEASED;
          lock_speed = SPD_STOP;
          lock_motor = 1'b0;
        end
      end
      ACT_ENGAGE: begin
        if (lock_phase == PH_RELEASED) lock_phase = PH_WANT_ENG;
      end
      ACT_RELEASE: begin
        if (lock_phase inside {PH_ENGAGED, PH_WANT_ENG, PH_PRE_ENG, PH_ENGAGING,
                               PH_STEPBACK}) lock_phase = PH_WANT_REL;
      end
      default: ;
    endcase

    case (lock_phase)
      PH_WANT_ENG: begin
        lock_tries = (req.gear_speed < lock_cfg.stopped_speed) ? lock_cfg.tries_stopped
                                                               : lock_cfg.tries_moving;
        if (lock_tries != 3'd0) begin
          lock_wait  = lock_cfg.wait_cycles;
          lock_phase = PH_PRE_ENG;
        end else begin
          lock_phase = PH_WANT_REL;
        end
      end
      PH_WANT_REL: begin
        lock_wait  = lock_cfg.wait_cycles;
        lock_speed = SPD_REL;
        lock_motor = 1'b1;
        lock_phase = PH_PRE_REL;
      end
      PH_PRE_ENG: begin
        lock_speed = SPD_ENG;
        lock_motor = 1'b1;
        if (lock_wait == 8'd0) lock_phase = PH_ENGAGING;
        else lock_wait--;
      end
      PH_PRE_REL: begin
        lock_speed = SPD_REL;
        lock_motor = 1'b1;
        if (lock_wait == 8'd0) lock_phase = PH_RELEASING;
        else lock_wait--;
      end
      PH_ENGAGING: begin
        // At a stall the position decides between engaged and another try.
        if (stall_seen(pos)) begin
          lock_stall = 8'd0;
          if (pos <= lock_cfg.engaged_limit) begin
            lock_speed = SPD_STOP;
            lock_motor = 1'b0;
            lock_lamp  = 1'b1;
            lock_phase = PH_ENGAGED;
          end else begin
            lock_speed = SPD_REL;
            lock_motor = 1'b1;
            lock_wait  = lock_cfg.wait_cycles;
            if (lock_tries > 3'd1) begin
              lock_tries--;
              lock_phase = PH_STEPBACK;
            end else begin
              lock_phase = PH_PRE_REL;
            end
          end
        end
      end
      PH_STEPBACK: begin
        if (lock_wait == 8'd0) begin
          lock_wait  = lock_cfg.wait_cycles;
          lock_speed = SPD_ENG;
          lock_motor = 1'b1;
          lock_phase = PH_PRE_ENG;
        end else begin
          lock_wait--;
        end
      end
      PH_RELEASING: begin
        if (stall_seen(pos) && pos > lock_cfg.release_limit) begin
          lock_stall = 8'd0;
          lock_speed = SPD_STOP;
          lock_motor = 1'b0;
          lock_lamp  = 1'b0;
          lock_phase = PH_RELEASED;
        end
      end
      default: ;
    endcase

    lock_last_pos = pos;
    res.phase         = lock_phase;
    res.speed_command = lock_speed;
    res.motor_active  = lock_motor;
    res.lamp_on       = lock_lamp;
    res.tries_rem     = lock_tries;
    return res;
  endfunction

  // Offers one request, waits for it to be taken and records its result.
  task automatic send_tick(les_req_t req);
    if (!steady_mode && $urandom_range(0, 99) < 5) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(advance_lock(req));
  endtask

  task automatic tick_with(action_e act, logic [13:0] speed, logic signed [PosW-1:0] pos);
    les_req_t req;
    req.action            = act;
    req.gear_speed        = speed;
    req.measured_position = pos;
    send_tick(req);
  endtask

  // Repeats one request until the predicted phase is reached, with a bound.
  task automatic run_until(phase_e target, action_e act, logic signed [PosW-1:0] pos);
    int n;
    n = 0;
    while (lock_phase != target && n < 40) begin
      tick_with(act, 14'd0, pos);
      n++;
    end
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all configuration registers; only called while the block is idle.
  task automatic program_lock(lock_cfg_t c);
    cfg_idx_e        idx;
    logic [PosW-1:0] data;
    idx = idx.first();
    do begin
      case (idx)
        CFG_WAIT_CYCLES:   data = PosW'(c.wait_cycles);
        CFG_STOPPED_SPEED: data = PosW'(c.stopped_speed);
        CFG_TRIES_STOPPED: data = PosW'(c.tries_stopped);
        CFG_TRIES_MOVING:  data = PosW'(c.tries_moving);
        CFG_STALL_LIMIT:   data = PosW'(c.stall_limit);
        CFG_ENGAGED_LIMIT: data = c.engaged_limit;
        CFG_RELEASE_LIMIT: data = c.release_limit;
        default:           data = '0;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i <= 1'b0;
    lock_cfg = c;
  endtask

  // Requests before homing are ignored; homing is taken only once.
  task automatic test_homing();
    tick_with(ACT_TICK, 14'h3FFF, 24'sh7FFFFF);
    tick_with(ACT_ENGAGE, 14'd0, 24'sh000000);
    tick_with(ACT_RELEASE, 14'h2AAA, 24'sh555555);
    tick_with(ACT_HOMED, 14'h1555, 24'sh800000);
    tick_with(ACT_HOMED, 14'h3FFF, 24'shAAAAAA);
    tick_with(ACT_TICK, 14'd0, 24'shFFFFFF);
  endtask

  // Zero budget, retries that run out, a clean engage and release, and a
  // second zero-budget engage at the speed threshold followed by a release request.
  task automatic test_engage_paths();
    settle();
    program_lock('{wait_cycles: 8'd0, stopped_speed: 14'd100, tries_stopped: 3'd2,
                   tries_moving: 3'd0, stall_limit: 8'd0, engaged_limit: 24'sd0,
                   release_limit: -24'sd32768});
    tick_with(ACT_ENGAGE, 14'h3FFF, 24'sh010000);
    run_until(PH_RELEASED, ACT_TICK, 24'sh010000);
    tick_with(ACT_ENGAGE, 14'd0, 24'sh010000);
    run_until(PH_RELEASED, ACT_TICK, 24'sh010000);
    tick_with(ACT_ENGAGE, 14'd99, -24'sd1);
    run_until(PH_ENGAGED, ACT_TICK, -24'sd1);
    tick_with(ACT_RELEASE, 14'd200, -24'sd1);
    run_until(PH_RELEASED, ACT_TICK, -24'sd1);
    tick_with(ACT_ENGAGE, 14'd100, 24'sh020000);
    tick_with(ACT_RELEASE, 14'd100, 24'sh020000);
    run_until(PH_RELEASED, ACT_TICK, 24'sh020000);
  endtask

  // Random ticks around the limits, with requests that follow the phase
  // so that full engage and release sequences happen.
  task automatic test_random_mix(lock_cfg_t c, int items, int hold_max, bit steady,
                                 int holdoff);
    les_req_t               req;
    logic signed [PosW-1:0] pos;
    int                     run_left;
    int                     r;
    settle();
    program_lock(c);
    steady_mode = steady;
    hold_left   = holdoff;
    run_left    = 0;
    pos         = '0;
    for (int n = 0; n < items; n++) begin
      // Hold the position for a while so that stalls are seen.
      if (run_left == 0) begin
        case ($urandom_range(0, 3))
          0:       pos = lock_cfg.engaged_limit - PosW'($urandom_range(0, 2));
          1:       pos = lock_cfg.engaged_limit + PosW'($urandom_range(1, 2));
          2:       pos = lock_cfg.release_limit + PosW'($urandom_range(0, 3)) - 24'sd1;
          default: pos = PosW'($urandom);
        endcase
        run_left = $urandom_range(1, hold_max);
      end
      run_left--;
      req.measured_position = pos;
      if ($urandom_range(0, 1) == 0) begin
        req.gear_speed = lock_cfg.stopped_speed - 14'($urandom_range(0, 1));
      end else begin
        req.gear_speed = 14'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        req.action = action_e'($urandom_range(0, 3));
      end else if (lock_phase == PH_RELEASED && r < 30) begin
        req.action = ACT_ENGAGE;
      end else if (lock_phase == PH_ENGAGED && r < 15) begin
        req.action = ACT_RELEASE;
      end else if (r < 6) begin
        req.action = ACT_RELEASE;
      end else begin
        req.action = ACT_TICK;
      end
      send_tick(req);
    end
    // Bring the lock home to released before the next settings.
    run_until(PH_RELEASED, ACT_RELEASE, 24'sh7FFFFF);
    steady_mode = 1'b0;
  endtask

  // The stall count saturates while engaging with an unreachable limit and
  // carries over into releasing, where a lower limit then ends it at once.
  task automatic test_stall_saturation();
    lock_cfg_t              c;
    logic signed [PosW-1:0] pos;
    c = '{wait_cycles: 8'd10, stopped_speed: 14'd8000, tries_stopped: 3'd1,
          tries_moving: 3'd2, stall_limit: 8'd255, engaged_limit: 24'sd4096,
          release_limit: -24'sd4096};
    pos = PosW'($urandom_range(0, 24'h7FFFFF));
    settle();
    program_lock(c);
    tick_with(ACT_ENGAGE, 14'($urandom), pos);
    repeat (300) tick_with(ACT_TICK, 14'($urandom), pos);
    tick_with(ACT_RELEASE, 14'($urandom), pos);
    repeat (20) tick_with(ACT_TICK, 14'($urandom), pos);
    settle();
    c.stall_limit = 8'd254;
    program_lock(c);
    repeat (3) tick_with(ACT_TICK, 14'($urandom), pos);
  endtask

  // Result stall: random, off in steady stretches, or held for a long count.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (steady_mode) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 9);
      end
    end
  end

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Compares every result taken from the block with the oldest expectation.
  initial begin
    les_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("phase", out_res_o.phase, want.phase);
          check_field("speed_command", 4'(out_res_o.speed_command), 4'(want.speed_command));
          check_field("motor_active", 4'(out_res_o.motor_active), 4'(want.motor_active));
          check_field("lamp_on", 4'(out_res_o.lamp_on), 4'(want.lamp_on));
          check_field("tries_rem", 4'(out_res_o.tries_rem), 4'(want.tries_rem));
        end
      end
    end
  end

  // Test sequence.
  initial begin
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_homing();
    test_engage_paths();
    // Moderate settings, with a long result hold-off early on.
    test_random_mix('{wait_cycles: 8'd3, stopped_speed: 14'd50, tries_stopped: 3'd3,
                      tries_moving: 3'd5, stall_limit: 8'd3, engaged_limit: 24'sd0,
                      release_limit: -24'sd32768}, 300, 8, 1'b0, 60);
    // Low extremes, run back to back with no idling.
    test_random_mix('{wait_cycles: 8'd0, stopped_speed: 14'd0, tries_stopped: 3'd7,
                      tries_moving: 3'd1, stall_limit: 8'd0, engaged_limit: 24'sh7FFFFF,
                      release_limit: 24'sh800000}, 250, 3, 1'b1, 0);
    // High extremes: almost always stopped with no budget.
    test_random_mix('{wait_cycles: 8'd1, stopped_speed: 14'h3FFF, tries_stopped: 3'd0,
                      tries_moving: 3'd7, stall_limit: 8'd1, engaged_limit: 24'sh800000,
                      release_limit: 24'sh7FFFFE}, 200, 4, 1'b0, 0);
    test_stall_saturation();
    settle();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
